// File: src/flpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flpw_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed port widths
  localparam int ID_PORT_W   = 8;
  localparam int TAG_W       = 8;
  localparam int PRIO_W      = 8;
  localparam int TIME_PORT_W = 32;
  localparam int STAT_W      = 32;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_IDLE      = 2'd1,
    ERR_NOT_OWNER = 2'd2,
    ERR_FULL      = 2'd3
  } err_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  typedef struct packed {
    logic count_req;
    logic count_svc;
    logic add_busy;
  } stats_cmd_t;

endpackage

`default_nettype wire

// File: src/facility_lock_priority_wait.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-owner lock with a priority wait queue.
//
// Input channel (in_*): one item per seize or release. A seize takes the lock
// at once when it is free, otherwise it waits in a sorted queue of
// QUEUE_DEPTH entries (lowest priority number first, ties by arrival). A
// release by the owner books the held time and hands the lock to the queue
// head, if any. Bad releases and seizes into a full queue report an error.
// Result channel (out_*): exactly one item per input item, in order, carrying
// the grant (if any), the error code and the running statistics.
//
// Path: the item is held in the input register, then one decision pass writes
// the result register. Throughput: one item per cycle while the receiver does
// not stall, set by the single decision pass over the register queue, whose
// compares for all entries run in parallel.
// Reset (rst_n low, synchronous) frees the lock, empties the queue and clears
// all counters; queue entries themselves are not cleared.
// When the receiver stalls, hold the result; one further item can still be
// taken into the input register, after which in_stall rises.
module facility_lock_priority_wait #(
  parameter int QUEUE_DEPTH = flpw_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = flpw_pkg::ID_BITS_DEF,
  parameter int TIME_BITS   = flpw_pkg::TIME_BITS_DEF,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             in_op,
  input  wire logic [flpw_pkg::ID_PORT_W-1:0]   in_requester,
  input  wire logic [flpw_pkg::TAG_W-1:0]       in_resume_tag,
  input  wire logic [flpw_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire logic [flpw_pkg::TIME_PORT_W-1:0] in_now,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             out_granted,
  output      logic [flpw_pkg::ID_PORT_W-1:0]   out_grant_requester,
  output      logic [flpw_pkg::TAG_W-1:0]       out_grant_tag,
  output      logic [flpw_pkg::TIME_PORT_W-1:0] out_grant_wait,
  output      logic [1:0]                       out_error,
  output      logic                             out_busy_res,
  output      logic [CW-1:0]                    out_waiting_count,
  output      logic [flpw_pkg::STAT_W-1:0]      out_total_requests,
  output      logic [flpw_pkg::STAT_W-1:0]      out_total_serviced,
  output      logic [flpw_pkg::STAT_W-1:0]      out_busy_time,
  output      logic [CW-1:0]                    out_max_waiting
);

  localparam int TAG_W  = flpw_pkg::TAG_W;
  localparam int PRIO_W = flpw_pkg::PRIO_W;
  localparam int IDP_W  = flpw_pkg::ID_PORT_W;
  localparam int TP_W   = flpw_pkg::TIME_PORT_W;
  localparam int SW     = flpw_pkg::STAT_W;

  // ---------------- input register ----------------
  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [ID_BITS-1:0]   s1_who_r;
  logic [TAG_W-1:0]     s1_tag_r;
  logic [PRIO_W-1:0]    s1_prio_r;
  logic [TIME_BITS-1:0] s1_now_r;

  logic in_take;
  logic go;   // the held item is decided this cycle

  assign go       = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload: truncate or widen to the internal id and time widths.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_who_r  <= ID_BITS'(in_requester);
      s1_tag_r  <= in_resume_tag;
      s1_prio_r <= in_priority_req;
      s1_now_r  <= TIME_BITS'(in_now);
    end
  end

  // ---------------- lock state ----------------
  logic                 held_r, held_nxt;
  logic [ID_BITS-1:0]   owner_r, owner_nxt;
  logic [TIME_BITS-1:0] hold_start_r, hold_start_nxt;
  logic [CW-1:0]        peak_r, peak_nxt;

  // ---------------- wait queue ----------------
  flpw_pkg::queue_cmd_t q_cmd;
  logic [ID_BITS-1:0]   q_head_who;
  logic [TAG_W-1:0]     q_head_tag;
  logic [TIME_BITS-1:0] q_head_arrived;
  logic [CW-1:0]        q_count;
  logic [CW-1:0]        q_count_after;
  logic                 q_full;

  flpw_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (q_cmd),
    .ins_who      (s1_who_r),
    .ins_tag      (s1_tag_r),
    .ins_prio     (s1_prio_r),
    .ins_arrived  (s1_now_r),
    .head_who     (q_head_who),
    .head_tag     (q_head_tag),
    .head_arrived (q_head_arrived),
    .count        (q_count)
  );

  assign q_full = (q_count == CW'(QUEUE_DEPTH));

  // ---------------- statistics ----------------
  flpw_pkg::stats_cmd_t st_cmd;
  logic [TIME_BITS-1:0] held_diff;
  logic [SW-1:0]        req_total_nxt;
  logic [SW-1:0]        svc_total_nxt;
  logic [TIME_BITS-1:0] busy_time_nxt;

  assign held_diff = s1_now_r - hold_start_r;

  flpw_stats #(
    .TIME_BITS (TIME_BITS)
  ) u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (st_cmd),
    .held_diff     (held_diff),
    .req_total_nxt (req_total_nxt),
    .svc_total_nxt (svc_total_nxt),
    .busy_time_nxt (busy_time_nxt)
  );

  // ---------------- decision pass ----------------
  logic                 grant;
  logic [ID_BITS-1:0]   grant_who;
  logic [TAG_W-1:0]     grant_tag;
  logic [TIME_BITS-1:0] grant_wait;
  flpw_pkg::err_t       err;

  always_comb begin
    held_nxt       = held_r;
    owner_nxt      = owner_r;
    hold_start_nxt = hold_start_r;
    grant          = 1'b0;
    grant_who      = '0;
    grant_tag      = '0;
    grant_wait     = '0;
    err            = flpw_pkg::ERR_OK;
    q_cmd          = '0;
    st_cmd         = '0;

    if (go) begin
      if (!s1_op_r) begin
        // seize: always counted, even when dropped
        st_cmd.count_req = 1'b1;
        if (!held_r) begin
          held_nxt       = 1'b1;
          owner_nxt      = s1_who_r;
          hold_start_nxt = s1_now_r;
          grant          = 1'b1;
          grant_who      = s1_who_r;
          grant_tag      = s1_tag_r;
        end else if (q_full) begin
          err = flpw_pkg::ERR_FULL;
        end else begin
          q_cmd.push = 1'b1;
        end
      end else begin
        if (!held_r) begin
          err = flpw_pkg::ERR_IDLE;
        end else if (s1_who_r != owner_r) begin
          err = flpw_pkg::ERR_NOT_OWNER;
        end else begin
          st_cmd.add_busy  = 1'b1;
          st_cmd.count_svc = 1'b1;
          if (q_count != '0) begin
            // hand over to the queue head
            q_cmd.pop      = 1'b1;
            owner_nxt      = q_head_who;
            hold_start_nxt = s1_now_r;
            grant          = 1'b1;
            grant_who      = q_head_who;
            grant_tag      = q_head_tag;
            grant_wait     = s1_now_r - q_head_arrived;
          end else begin
            held_nxt  = 1'b0;
            owner_nxt = '0;
          end
        end
      end
    end
  end

  always_comb begin
    q_count_after = q_count;
    if (q_cmd.pop) begin
      q_count_after = q_count - CW'(1);
    end else if (q_cmd.push) begin
      q_count_after = q_count + CW'(1);
    end
    peak_nxt = (q_count_after > peak_r) ? q_count_after : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b0;
      owner_r      <= '0;
      hold_start_r <= '0;
      peak_r       <= '0;
    end else begin
      held_r       <= held_nxt;
      owner_r      <= owner_nxt;
      hold_start_r <= hold_start_nxt;
      peak_r       <= peak_nxt;
    end
  end

  // ---------------- result register ----------------
  logic              out_valid_r;
  logic              out_granted_r;
  logic [IDP_W-1:0]  out_grant_requester_r;
  logic [TAG_W-1:0]  out_grant_tag_r;
  logic [TP_W-1:0]   out_grant_wait_r;
  logic [1:0]        out_error_r;
  logic              out_busy_res_r;
  logic [CW-1:0]     out_waiting_count_r;
  logic [SW-1:0]     out_total_requests_r;
  logic [SW-1:0]     out_total_serviced_r;
  logic [SW-1:0]     out_busy_time_r;
  logic [CW-1:0]     out_max_waiting_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_granted_r         <= grant;
      out_grant_requester_r <= IDP_W'(grant_who);
      out_grant_tag_r       <= grant_tag;
      out_grant_wait_r      <= TP_W'(grant_wait);
      out_error_r           <= err;
      out_busy_res_r        <= held_nxt;
      out_waiting_count_r   <= q_count_after;
      out_total_requests_r  <= req_total_nxt;
      out_total_serviced_r  <= svc_total_nxt;
      out_busy_time_r       <= SW'(busy_time_nxt);
      out_max_waiting_r     <= peak_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_grant_requester = out_grant_requester_r;
  assign out_grant_tag       = out_grant_tag_r;
  assign out_grant_wait      = out_grant_wait_r;
  assign out_error           = out_error_r;
  assign out_busy_res        = out_busy_res_r;
  assign out_waiting_count   = out_waiting_count_r;
  assign out_total_requests  = out_total_requests_r;
  assign out_total_serviced  = out_total_serviced_r;
  assign out_busy_time       = out_busy_time_r;
  assign out_max_waiting     = out_max_waiting_r;

endmodule

`default_nettype wire

// File: src/flpw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted register queue: lowest priority number at entry 0, ties in arrival order.
module flpw_queue #(
  parameter int QUEUE_DEPTH = flpw_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = flpw_pkg::ID_BITS_DEF,
  parameter int TIME_BITS   = flpw_pkg::TIME_BITS_DEF,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire flpw_pkg::queue_cmd_t       cmd,
  input  wire logic [ID_BITS-1:0]         ins_who,
  input  wire logic [flpw_pkg::TAG_W-1:0] ins_tag,
  input  wire logic [flpw_pkg::PRIO_W-1:0] ins_prio,
  input  wire logic [TIME_BITS-1:0]       ins_arrived,
  output      logic [ID_BITS-1:0]         head_who,
  output      logic [flpw_pkg::TAG_W-1:0] head_tag,
  output      logic [TIME_BITS-1:0]       head_arrived,
  output      logic [CW-1:0]              count
);

  logic [ID_BITS-1:0]          who_r     [QUEUE_DEPTH];
  logic [flpw_pkg::TAG_W-1:0]  tag_r     [QUEUE_DEPTH];
  logic [flpw_pkg::PRIO_W-1:0] prio_r    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]        arrived_r [QUEUE_DEPTH];
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;

  // le[i]: entry i is live and goes before the new request
  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH:0]   le_ext;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (prio_r[i] <= ins_prio);
    end
    le_ext = {le, 1'b1};
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
      localparam int UP = (g < QUEUE_DEPTH - 1) ? g + 1 : g;
      localparam int DN = (g > 0) ? g - 1 : g;

      always_ff @(posedge clk) begin
        if (cmd.pop) begin
          who_r[g]     <= who_r[UP];
          tag_r[g]     <= tag_r[UP];
          prio_r[g]    <= prio_r[UP];
          arrived_r[g] <= arrived_r[UP];
        end else if (cmd.push && !le[g]) begin
          if (le_ext[g]) begin
            who_r[g]     <= ins_who;
            tag_r[g]     <= ins_tag;
            prio_r[g]    <= ins_prio;
            arrived_r[g] <= ins_arrived;
          end else begin
            who_r[g]     <= who_r[DN];
            tag_r[g]     <= tag_r[DN];
            prio_r[g]    <= prio_r[DN];
            arrived_r[g] <= arrived_r[DN];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_who     = who_r[0];
  assign head_tag     = tag_r[0];
  assign head_arrived = arrived_r[0];
  assign count        = count_r;

endmodule

`default_nettype wire

// File: src/flpw_stats.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturating request, service and busy-time counters.
module flpw_stats #(
  parameter int TIME_BITS = flpw_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire flpw_pkg::stats_cmd_t        cmd,
  input  wire logic [TIME_BITS-1:0]        held_diff,
  output      logic [flpw_pkg::STAT_W-1:0] req_total_nxt,
  output      logic [flpw_pkg::STAT_W-1:0] svc_total_nxt,
  output      logic [TIME_BITS-1:0]        busy_time_nxt
);

  localparam int SW = flpw_pkg::STAT_W;

  logic [SW-1:0]        req_total_r;
  logic [SW-1:0]        svc_total_r;
  logic [TIME_BITS-1:0] busy_time_r;
  logic [TIME_BITS:0]   busy_sum;

  always_comb begin
    busy_sum      = {1'b0, busy_time_r} + {1'b0, held_diff};
    req_total_nxt = req_total_r;
    svc_total_nxt = svc_total_r;
    busy_time_nxt = busy_time_r;
    if (cmd.count_req && !(&req_total_r)) begin
      req_total_nxt = req_total_r + SW'(1);
    end
    if (cmd.count_svc && !(&svc_total_r)) begin
      svc_total_nxt = svc_total_r + SW'(1);
    end
    if (cmd.add_busy) begin
      busy_time_nxt = busy_sum[TIME_BITS] ? '1 : busy_sum[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_total_r <= '0;
      svc_total_r <= '0;
      busy_time_r <= '0;
    end else begin
      req_total_r <= req_total_nxt;
      svc_total_r <= svc_total_nxt;
      busy_time_r <= busy_time_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/flpw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module flpw_checker #(
  parameter int CW = 5
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic          out_granted,
  input wire logic [7:0]    out_grant_requester,
  input wire logic [7:0]    out_grant_tag,
  input wire logic [31:0]   out_grant_wait,
  input wire logic [1:0]    out_error,
  input wire logic          out_busy_res,
  input wire logic [CW-1:0] out_waiting_count,
  input wire logic [CW-1:0] out_max_waiting
);

  // No grant, no grant details.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |->
      (out_grant_requester == '0 && out_grant_tag == '0 && out_grant_wait == '0))
    else $error("grant fields set without a grant");

  // An error never comes with a grant.
  a_error_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != flpw_pkg::ERR_OK) |-> !out_granted)
    else $error("grant reported together with an error");

  // Waiters imply a held lock.
  a_wait_needs_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_waiting_count != '0) |-> out_busy_res)
    else $error("requests waiting on a free lock");

  // Peak queue length bounds the current one.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_waiting_count <= out_max_waiting))
    else $error("waiting count above its peak");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_error) && $stable(out_granted) &&
       $stable(out_waiting_count)))
    else $error("stalled result changed");

endmodule

bind facility_lock_priority_wait flpw_checker #(
  .CW ($clog2(QUEUE_DEPTH + 1))
) u_flpw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_granted         (out_granted),
  .out_grant_requester (out_grant_requester),
  .out_grant_tag       (out_grant_tag),
  .out_grant_wait      (out_grant_wait),
  .out_error           (out_error),
  .out_busy_res        (out_busy_res),
  .out_waiting_count   (out_waiting_count),
  .out_max_waiting     (out_max_waiting)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic OP_SEIZE   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam int   LOCK_DEPTH = flpw_pkg::QUEUE_DEPTH_DEF;
  localparam int   CW         = $clog2(flpw_pkg::QUEUE_DEPTH_DEF + 1);

  // One waiting client, as held in the sorted wait queue
  typedef struct {
    logic [7:0]  who;
    logic [7:0]  tag;
    logic [7:0]  prio;
    logic [31:0] arrived;
  } waiter_t;

  // Everything one result item carries
  typedef struct {
    logic           granted;
    logic [7:0]     grant_who;
    logic [7:0]     grant_tag;
    logic [31:0]    grant_wait;
    flpw_pkg::err_t error;
    logic           lock_held;
    logic [CW-1:0]  queued;
    logic [31:0]    requests;
    logic [31:0]    serviced;
    logic [31:0]    busy_ticks;
    logic [CW-1:0]  peak_queued;
  } lock_result_t;

  // Shadow of the lock: predicts each result item and checks the block's results
  class lock_scoreboard;
    logic          held;
    logic [7:0]    owner;
    logic [31:0]   hold_start;
    waiter_t       waiters[$];
    logic [31:0]   requests;
    logic [31:0]   serviced;
    logic [31:0]   busy_ticks;
    int            peak_queued;
    lock_result_t  expected_results[$];
    int            mismatches;

    function new();
      held        = 1'b0;
      owner       = '0;
      hold_start  = '0;
      requests    = '0;
      serviced    = '0;
      busy_ticks  = '0;
      peak_queued = 0;
      mismatches  = 0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? '1 : sum[31:0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted item to the shadow state and queue its result
    function void note_item(logic op, logic [7:0] who, logic [7:0] tag,
                            logic [7:0] prio, logic [31:0] now);
      lock_result_t r;
      waiter_t      w;
      int           pos;
      r = '{granted: 1'b0, grant_who: '0, grant_tag: '0, grant_wait: '0,
            error: flpw_pkg::ERR_OK, lock_held: 1'b0, queued: '0, requests: '0,
            serviced: '0, busy_ticks: '0, peak_queued: '0};
      if (op == OP_SEIZE) begin
        requests = sat_add(requests, 32'd1);
        if (!held) begin
          held        = 1'b1;
          owner       = who;
          hold_start  = now;
          r.granted   = 1'b1;
          r.grant_who = who;
          r.grant_tag = tag;
        end else if (waiters.size() >= LOCK_DEPTH) begin
          r.error = flpw_pkg::ERR_FULL;
        end else begin
          // equal priorities keep arrival order
          pos = 0;
          while (pos < waiters.size() && waiters[pos].prio <= prio) pos++;
          w = '{who: who, tag: tag, prio: prio, arrived: now};
          waiters.insert(pos, w);
          if (waiters.size() > peak_queued) peak_queued = waiters.size();
        end
      end else begin
        if (!held) begin
          r.error = flpw_pkg::ERR_IDLE;
        end else if (who != owner) begin
          r.error = flpw_pkg::ERR_NOT_OWNER;
        end else begin
          busy_ticks = sat_add(busy_ticks, now - hold_start);
          serviced   = sat_add(serviced, 32'd1);
          held       = 1'b0;
          owner      = '0;
          if (waiters.size() > 0) begin
            w            = waiters.pop_front();
            held         = 1'b1;
            owner        = w.who;
            hold_start   = now;
            r.granted    = 1'b1;
            r.grant_who  = w.who;
            r.grant_tag  = w.tag;
            r.grant_wait = now - w.arrived;
          end
        end
      end
      r.lock_held   = held;
      r.queued      = CW'(waiters.size());
      r.requests    = requests;
      r.serviced    = serviced;
      r.busy_ticks  = busy_ticks;
      r.peak_queued = CW'(peak_queued);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, got);
      end
    endfunction

    // Compare one accepted result item against the oldest prediction
    function void check_result(lock_result_t got);
      lock_result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result item with none expected, expected none, actual error 0x%0h",
                 $time, got.error);
        return;
      end
      exp = expected_results.pop_front();
      check_field("granted", exp.granted, got.granted);
      check_field("grant_requester", exp.grant_who, got.grant_who);
      check_field("grant_tag", exp.grant_tag, got.grant_tag);
      check_field("grant_wait", exp.grant_wait, got.grant_wait);
      check_field("error", exp.error, got.error);
      check_field("busy_res", exp.lock_held, got.lock_held);
      check_field("waiting_count", exp.queued, got.queued);
      check_field("total_requests", exp.requests, got.requests);
      check_field("total_serviced", exp.serviced, got.serviced);
      check_field("busy_time", exp.busy_ticks, got.busy_ticks);
      check_field("max_waiting", exp.peak_queued, got.peak_queued);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_op = OP_SEIZE;
  logic [7:0]    in_requester = '0;
  logic [7:0]    in_resume_tag = '0;
  logic [7:0]    in_priority_req = '0;
  logic [31:0]   in_now = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_granted;
  logic [7:0]    out_grant_requester;
  logic [7:0]    out_grant_tag;
  logic [31:0]   out_grant_wait;
  logic [1:0]    out_error;
  logic          out_busy_res;
  logic [CW-1:0] out_waiting_count;
  logic [31:0]   out_total_requests;
  logic [31:0]   out_total_serviced;
  logic [31:0]   out_busy_time;
  logic [CW-1:0] out_max_waiting;

  // Idling rates, in cycles per hundred, and the receiver's long hold-off
  int unsigned sender_idle_pct = 28;
  int unsigned receiver_idle_pct = 47;
  int unsigned hold_off_cycles = 0;
  // Running time base for random items
  logic [31:0] tick_base = 32'd1000;

  lock_scoreboard sb = new();

  facility_lock_priority_wait dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_requester        (in_requester),
    .in_resume_tag       (in_resume_tag),
    .in_priority_req     (in_priority_req),
    .in_now              (in_now),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_grant_requester (out_grant_requester),
    .out_grant_tag       (out_grant_tag),
    .out_grant_wait      (out_grant_wait),
    .out_error           (out_error),
    .out_busy_res        (out_busy_res),
    .out_waiting_count   (out_waiting_count),
    .out_total_requests  (out_total_requests),
    .out_total_serviced  (out_total_serviced),
    .out_busy_time       (out_busy_time),
    .out_max_waiting     (out_max_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a counted stretch when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles = hold_off_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Result monitor: values read here are those the block saw at this edge
  always @(posedge clk) begin
    lock_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.granted     = out_granted;
      got.grant_who   = out_grant_requester;
      got.grant_tag   = out_grant_tag;
      got.grant_wait  = out_grant_wait;
      got.error       = flpw_pkg::err_t'(out_error);
      got.lock_held   = out_busy_res;
      got.queued      = out_waiting_count;
      got.requests    = out_total_requests;
      got.serviced    = out_total_serviced;
      got.busy_ticks  = out_busy_time;
      got.peak_queued = out_max_waiting;
      sb.check_result(got);
    end
  end

  // Offer one item, idling first at the sender's rate; return once it is taken.
  // Note the item in the shadow before the next one is chosen, so the
  // random generator always sees the lock state as the block will.
  task automatic send_item(input logic op, input logic [7:0] who, input logic [7:0] tag,
                           input logic [7:0] prio, input logic [31:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_requester    <= who;
    in_resume_tag   <= tag;
    in_priority_req <= prio;
    in_now          <= now;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(op, who, tag, prio, now);
  endtask

  // Hold the input idle until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: seizes from a small client pool and releases by the
  // owner, with some releases while idle or by the wrong client as noise
  task automatic random_item(input int unsigned seize_pct);
    logic [7:0]  who;
    logic [7:0]  prio;
    int unsigned pick;
    tick_base = tick_base + $urandom_range(0, 40);
    who  = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    prio = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (!sb.held) begin
      if (pick < 85) send_item(OP_SEIZE, who, 8'($urandom), prio, tick_base);
      else send_item(OP_RELEASE, who, 8'($urandom), prio, tick_base);
    end else if (pick < seize_pct) begin
      send_item(OP_SEIZE, who, 8'($urandom), prio, tick_base);
    end else if (pick < seize_pct + 8) begin
      send_item(OP_RELEASE, who, 8'($urandom), prio, tick_base);
    end else begin
      send_item(OP_RELEASE, sb.owner, 8'($urandom), prio, tick_base);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: release while idle, an immediate grant at the top of time,
    // a release by the wrong client, then the owner queueing behind itself
    send_item(OP_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
    send_item(OP_SEIZE, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 8'h00, 8'h00, 8'h00, 32'd5);
    send_item(OP_SEIZE, 8'hFF, 8'h00, 8'hFF, 32'd10);
    // Equal priorities: client 1 arrived first and must be served first
    send_item(OP_SEIZE, 8'h01, 8'h01, 8'h07, 32'd11);
    send_item(OP_SEIZE, 8'h02, 8'h02, 8'h07, 32'd12);
    send_item(OP_SEIZE, 8'h03, 8'h03, 8'h00, 32'd13);
    // Fill the queue to its last slot, then overflow it
    for (int i = 0; i < LOCK_DEPTH - 4; i++)
      send_item(OP_SEIZE, 8'(8'h10 + i), 8'(8'hF0 - i), 8'((i % 4) + 5), 32'(20 + i));
    send_item(OP_SEIZE, 8'h80, 8'h55, 8'h00, 32'd40);
    // Releases across the time wrap hand the lock to the queue head
    send_item(OP_RELEASE, 8'hFF, 8'h00, 8'h00, 32'd100);
    send_item(OP_RELEASE, 8'h03, 8'hAA, 8'h00, 32'd200);
    drain_results();

    // Random phases: receiver idles more, then sender idles more, then neither
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 47 : 0;
      receiver_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 28 : 0;
      // with no idling, hold the receiver off long enough to back up the input
      if (phase == 2) hold_off_cycles = 60;
      for (int n = 0; n < 140; n++)
        random_item((phase == 0) ? 55 : (phase == 1) ? 40 : 50);
      drain_results();
    end

    // Time going backwards: a near-full-range interval saturates the busy time,
    // and a further release must leave it saturated
    if (!sb.held) send_item(OP_SEIZE, 8'h21, 8'h5A, 8'h10, tick_base);
    send_item(OP_RELEASE, sb.owner, 8'h00, 8'h00, sb.hold_start - 32'd1);
    if (sb.held) send_item(OP_RELEASE, sb.owner, 8'h00, 8'h00, sb.hold_start + 32'd3);

    drain_results();
    // allow for a stray result beyond the latency
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("facility_lock_priority_wait regression: pass");
    end else begin
      $display("facility_lock_priority_wait regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("facility_lock_priority_wait regression: fail");
    $finish;
  end

endmodule
